[rtl/ubsc_pkg.sv]
// shared types and codes for the utf-16 byte stream codec
`default_nettype none
package ubsc_pkg;

    localparam int DATA_W  = 21;
    localparam int WORDS_N = 3;

    localparam logic [1:0] KIND_DECODE = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] OUT_CP     = 2'd0;
    localparam logic [1:0] OUT_BYTE   = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SURROGATE = 2'd1;
    localparam logic [1:0] ERR_END       = 2'd2;
    localparam logic [1:0] ERR_INVALID   = 2'd3;

    localparam logic [0:0] REG_START_BIG_ENDIAN = 1'd0;
    localparam logic [0:0] REG_START_BOM_FLAG   = 1'd1;

    localparam logic [15:0] WORD_BOM      = 16'hFEFF;
    localparam logic [15:0] WORD_BOM_SWAP = 16'hFFFE;
    localparam logic [15:0] LEAD_LO       = 16'hD800;
    localparam logic [15:0] LEAD_HI       = 16'hDBFF;
    localparam logic [15:0] TRAIL_LO      = 16'hDC00;
    localparam logic [15:0] TRAIL_HI      = 16'hDFFF;
    localparam logic [DATA_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [DATA_W-1:0] CP_MAX    = 21'h10FFFF;

    // one request's worth of results: words to send as bytes, then an optional tail
    typedef struct packed {
        logic [WORDS_N-1:0][15:0] words;
        logic [1:0]               nwords;
        logic                     has_tail;
        logic [1:0]               tail_kind;
        logic [DATA_W-1:0]        tail_value;
        logic [1:0]               tail_err;
        logic                     endian;
        logic                     bom;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/utf16_byte_stream_codec_top.sv]
// utf-16 byte stream codec: front end, command queue and result sequencer
// a request that gives results enters the command queue when it is accepted
// throughput: one request per cycle while the queue is not full; results drain one per
//   cycle while ready; an encode request gives 1 to 6 beats, walked by the beat counter
// the two-entry command queue lets the front keep accepting while results wait
// reset: asynchronous, active low; flags little endian and clear, nothing pending
`default_nettype none
module utf16_byte_stream_codec_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [0:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [20:0] data, zero fill above
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [20:0] value, [22:21] error,
                                             // [23] big_endian_now, [24] bom_seen
    output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
    output logic             m_axis_tlast
);
    import ubsc_pkg::*;

    logic        q_full, q_push, q_pop, q_not_empty;
    cmd_t        push_cmd, head_cmd;
    logic [20:0] value;
    logic [1:0]  error;
    logic        endian, bom;

    ubsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_data   (s_axis_tdata[20:0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    ubsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    ubsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (m_axis_tuser),
        .out_value   (value),
        .out_error   (error),
        .out_endian  (endian),
        .out_bom     (bom),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, bom, endian, error, value};

endmodule
`default_nettype wire

[rtl/ubsc_front.sv]
// front end: takes requests, runs the decode state and builds result commands
`default_nettype none
module ubsc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [0:0]           cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_kind,
    input  wire logic [20:0]          in_data,
    input  wire logic                 q_full,
    output logic                      q_push,
    output ubsc_pkg::cmd_t            q_cmd
);
    import ubsc_pkg::*;

    logic        endian_reg, endian_next;
    logic        bom_reg, bom_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        have_byte_reg, have_byte_next;
    logic [9:0]  held_lead_reg, held_lead_next;
    logic        have_lead_reg, have_lead_next;

    logic        accept;
    logic [15:0] w;
    logic [7:0]  b;
    logic [DATA_W-1:0] d;
    logic        off;
    cmd_t        cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data[7:0];
    assign d        = in_data - SUPP_BASE;
    assign w        = endian_reg ? {held_byte_reg, b} : {b, held_byte_reg};

    always_comb
    begin
        endian_next    = endian_reg;
        bom_next       = bom_reg;
        held_byte_next = held_byte_reg;
        have_byte_next = have_byte_reg;
        held_lead_next = held_lead_reg;
        have_lead_next = have_lead_reg;
        off            = 1'b0;
        cmd            = '0;
        case (in_kind)
            KIND_DECODE:
            begin
                if (!have_byte_reg)
                begin
                    held_byte_next = b;
                    have_byte_next = 1'b1;
                end
                else
                begin
                    have_byte_next = 1'b0;
                    held_byte_next = '0;
                    if (have_lead_reg)
                    begin
                        have_lead_next = 1'b0;
                        held_lead_next = '0;
                        cmd.has_tail   = 1'b1;
                        if (w >= TRAIL_LO && w <= TRAIL_HI)
                        begin
                            cmd.tail_kind  = OUT_CP;
                            cmd.tail_value = SUPP_BASE + {1'b0, held_lead_reg, w[9:0]};
                        end
                        else
                        begin
                            cmd.tail_kind = OUT_STATUS;
                            cmd.tail_err  = ERR_SURROGATE;
                        end
                    end
                    else if (w >= LEAD_LO && w <= LEAD_HI)
                    begin
                        held_lead_next = w[9:0];
                        have_lead_next = 1'b1;
                    end
                    else if (w >= TRAIL_LO && w <= TRAIL_HI)
                    begin
                        cmd.has_tail  = 1'b1;
                        cmd.tail_kind = OUT_STATUS;
                        cmd.tail_err  = ERR_SURROGATE;
                    end
                    else if (w == WORD_BOM)
                    begin
                        bom_next = 1'b1;
                    end
                    else if (w == WORD_BOM_SWAP)
                    begin
                        bom_next    = 1'b1;
                        endian_next = !endian_reg;
                    end
                    else
                    begin
                        cmd.has_tail   = 1'b1;
                        cmd.tail_kind  = OUT_CP;
                        cmd.tail_value = {5'd0, w};
                    end
                end
            end
            KIND_ENCODE:
            begin
                if (bom_reg)
                begin
                    cmd.words[0] = WORD_BOM;
                    off          = 1'b1;
                    bom_next     = 1'b0;
                end
                if (in_data > CP_MAX
                    || (in_data >= {5'd0, LEAD_LO} && in_data <= {5'd0, TRAIL_HI}))
                begin
                    held_byte_next = '0;
                    have_byte_next = 1'b0;
                    held_lead_next = '0;
                    have_lead_next = 1'b0;
                    cmd.nwords     = {1'b0, off};
                    cmd.has_tail   = 1'b1;
                    cmd.tail_kind  = OUT_STATUS;
                    cmd.tail_err   = ERR_INVALID;
                end
                else if (in_data < SUPP_BASE)
                begin
                    cmd.words[{1'b0, off}] = in_data[15:0];
                    cmd.nwords             = {1'b0, off} + 2'd1;
                end
                else
                begin
                    cmd.words[{1'b0, off}]       = LEAD_LO | {6'd0, d[19:10]};
                    cmd.words[{1'b0, off} + 2'd1] = TRAIL_LO | {6'd0, d[9:0]};
                    cmd.nwords                   = {1'b0, off} + 2'd2;
                end
            end
            KIND_END:
            begin
                held_byte_next = '0;
                have_byte_next = 1'b0;
                held_lead_next = '0;
                have_lead_next = 1'b0;
                cmd.has_tail   = 1'b1;
                cmd.tail_kind  = OUT_STATUS;
                cmd.tail_err   = (have_byte_reg || have_lead_reg) ? ERR_END : ERR_NONE;
            end
            default:
            begin
                // no operation
            end
        endcase
        cmd.endian = endian_next;
        cmd.bom    = bom_next;
    end

    assign q_push = accept && (cmd.has_tail || (cmd.nwords != 2'd0));
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            endian_reg    <= 1'b0;
            bom_reg       <= 1'b0;
            held_byte_reg <= '0;
            have_byte_reg <= 1'b0;
            held_lead_reg <= '0;
            have_lead_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                endian_reg    <= endian_next;
                bom_reg       <= bom_next;
                held_byte_reg <= held_byte_next;
                have_byte_reg <= have_byte_next;
                held_lead_reg <= held_lead_next;
                have_lead_reg <= have_lead_next;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_START_BIG_ENDIAN)
                    endian_reg <= cfg_data[0];
                else if (cfg_index == REG_START_BOM_FLAG)
                    bom_reg <= cfg_data[0];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/ubsc_queue.sv]
// two-entry command queue between front and back end
`default_nettype none
module ubsc_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  ubsc_pkg::cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output ubsc_pkg::cmd_t head_cmd
);
    import ubsc_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/ubsc_back.sv]
// back end: walks one command out as byte beats and an optional final tail beat
`default_nettype none
module ubsc_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_not_empty,
    input  ubsc_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [1:0]     out_kind,
    output logic [20:0]    out_value,
    output logic [1:0]     out_error,
    output logic           out_endian,
    output logic           out_bom,
    output logic           out_last
);
    import ubsc_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  nbytes;
    logic [2:0]  total;
    logic        is_byte;
    logic [15:0] word;
    logic [7:0]  byte_sel;
    logic        beat_done;

    assign nbytes   = {q_cmd.nwords, 1'b0};
    assign total    = nbytes + {2'd0, q_cmd.has_tail};
    assign is_byte  = (pos_reg < nbytes);
    assign word     = q_cmd.words[pos_reg[2:1]];
    // first byte of a word is the high one in big endian order
    assign byte_sel = (pos_reg[0] == q_cmd.endian) ? word[7:0] : word[15:8];

    assign out_valid  = q_not_empty;
    assign out_kind   = is_byte ? OUT_BYTE : q_cmd.tail_kind;
    assign out_value  = is_byte ? {13'd0, byte_sel} : q_cmd.tail_value;
    assign out_error  = is_byte ? ERR_NONE : q_cmd.tail_err;
    assign out_endian = q_cmd.endian;
    assign out_bom    = q_cmd.bom;
    assign out_last   = (pos_reg == total - 3'd1);

    assign beat_done = out_valid && out_ready;
    assign q_pop     = beat_done && out_last;

    always_comb
    begin
        pos_next = pos_reg;
        if (beat_done)
            pos_next = out_last ? 3'd0 : pos_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule
`default_nettype wire

[dv/utf16_byte_stream_codec_top_test.sv]
// self-checking testbench for the utf-16 byte stream codec top level
`default_nettype none
module utf16_byte_stream_codec_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ubsc_pkg::*;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 20;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] value;
        logic [1:0]        err;
        logic              be;
        logic              bom;
        logic              last;
    } result_t;

    class codec_scoreboard;
        bit        endian_flag;
        bit        bom_flag;
        bit        have_byte;
        bit        have_lead;
        bit [7:0]  held_byte;
        bit [9:0]  lead_bits;
        result_t   expected_results[$];
        result_t   step_results[$];

        function void load_reg(logic [0:0] idx, logic [0:0] val);
            if (idx == REG_START_BIG_ENDIAN)
                endian_flag = val;
            else
                bom_flag = val;
        endfunction

        function void drop_pending();
            have_byte = 0;
            held_byte = '0;
            have_lead = 0;
            lead_bits = '0;
        endfunction

        function void put(logic [1:0] k, logic [DATA_W-1:0] v, logic [1:0] e);
            result_t r;
            r = '0;
            r.kind = k;
            r.value = v;
            r.err = e;
            step_results.push_back(r);
        endfunction

        function void put_word(logic [15:0] w);
            if (endian_flag)
            begin
                put(OUT_BYTE, DATA_W'(w[15:8]), ERR_NONE);
                put(OUT_BYTE, DATA_W'(w[7:0]), ERR_NONE);
            end
            else
            begin
                put(OUT_BYTE, DATA_W'(w[7:0]), ERR_NONE);
                put(OUT_BYTE, DATA_W'(w[15:8]), ERR_NONE);
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [15:0] w;
            if (!have_byte)
            begin
                held_byte = b;
                have_byte = 1;
                return;
            end
            w = endian_flag ? {held_byte, b} : {b, held_byte};
            have_byte = 0;
            held_byte = '0;
            if (have_lead)
            begin
                if (w >= TRAIL_LO && w <= TRAIL_HI)
                begin
                    put(OUT_CP, SUPP_BASE + DATA_W'({lead_bits, w[9:0]}), ERR_NONE);
                    have_lead = 0;
                    lead_bits = '0;
                end
                else
                begin
                    drop_pending();
                    put(OUT_STATUS, '0, ERR_SURROGATE);
                end
            end
            else if (w >= LEAD_LO && w <= LEAD_HI)
            begin
                lead_bits = w[9:0];
                have_lead = 1;
            end
            else if (w >= TRAIL_LO && w <= TRAIL_HI)
            begin
                drop_pending();
                put(OUT_STATUS, '0, ERR_SURROGATE);
            end
            else if (w == WORD_BOM)
                bom_flag = 1;
            else if (w == WORD_BOM_SWAP)
            begin
                bom_flag = 1;
                endian_flag = ~endian_flag;
            end
            else
                put(OUT_CP, DATA_W'(w), ERR_NONE);
        endfunction

        function void encode_point(logic [DATA_W-1:0] c);
            logic [DATA_W-1:0] d;
            if (bom_flag)
            begin
                put_word(WORD_BOM);
                bom_flag = 0;
            end
            if (c > CP_MAX || (c >= DATA_W'(LEAD_LO) && c <= DATA_W'(TRAIL_HI)))
            begin
                drop_pending();
                put(OUT_STATUS, '0, ERR_INVALID);
            end
            else if (c < SUPP_BASE)
                put_word(c[15:0]);
            else
            begin
                d = c - SUPP_BASE;
                put_word(LEAD_LO | {6'b0, d[19:10]});
                put_word(TRAIL_LO | {6'b0, d[9:0]});
            end
        endfunction

        // work out every result one accepted request causes
        function void note_request(logic [1:0] k, logic [DATA_W-1:0] d);
            result_t r;
            step_results.delete();
            case (k)
                KIND_DECODE: decode_byte(d[7:0]);
                KIND_ENCODE: encode_point(d);
                KIND_END:
                begin
                    if (have_byte || have_lead)
                    begin
                        drop_pending();
                        put(OUT_STATUS, '0, ERR_END);
                    end
                    else
                        put(OUT_STATUS, '0, ERR_NONE);
                end
                default: ;
            endcase
            // flags are the ones left after the whole request
            foreach (step_results[i])
            begin
                r = step_results[i];
                r.be = endian_flag;
                r.bom = bom_flag;
                r.last = (i == step_results.size() - 1);
                expected_results.push_back(r);
            end
        endfunction

        function bit check_result(result_t got, output string msg);
            result_t want;
            string bad;
            msg = "";
            if (expected_results.size() == 0)
            begin
                msg = $sformatf("result with none expected: kind %0d value %h err %0d",
                                got.kind, got.value, got.err);
                return 0;
            end
            want = expected_results.pop_front();
            bad = "";
            if (got.kind != want.kind) bad = {bad, " out_kind"};
            if (got.value != want.value) bad = {bad, " value"};
            if (got.err != want.err) bad = {bad, " error"};
            if (got.be != want.be) bad = {bad, " big_endian_now"};
            if (got.bom != want.bom) bad = {bad, " bom_seen"};
            if (got.last != want.last) bad = {bad, " last"};
            if (bad == "")
                return 1;
            msg = $sformatf("wrong%s: got %0d/%h/%0d/%0d/%0d/%0d want %0d/%h/%0d/%0d/%0d/%0d",
                            bad, got.kind, got.value, got.err, got.be, got.bom, got.last,
                            want.kind, want.value, want.err, want.be, want.bom, want.last);
            return 0;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [0:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    codec_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    utf16_byte_stream_codec_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("utf16_byte_stream_codec_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        result_t got;
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.value = m_axis_tdata[20:0];
            got.err = m_axis_tdata[22:21];
            got.be = m_axis_tdata[23];
            got.bom = m_axis_tdata[24];
            got.last = m_axis_tlast;
            results_seen++;
            if (!sb.check_result(got, msg))
                report(msg);
        end
    end

    // valid stays high between back-to-back requests
    task automatic send_item(input logic [1:0] k, input logic [DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= k;
        s_axis_tdata <= {3'b000, d};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(k, d);
        if (k != KIND_NOP)
            requests_sent++;
    endtask

    task automatic send_pair(input logic [7:0] b0, input logic [7:0] b1);
        send_item(KIND_DECODE, DATA_W'(b0));
        send_item(KIND_DECODE, DATA_W'(b1));
    endtask

    task automatic send_word(input logic [15:0] w);
        if (sb.endian_flag)
            send_pair(w[15:8], w[7:0]);
        else
            send_pair(w[7:0], w[15:8]);
    endtask

    // requests that give no result may still be in flight, so settle afterwards
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [0:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.load_reg(idx, val);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_code_point();
        logic [DATA_W-1:0] cp;
        case ($urandom_range(5))
            0: cp = DATA_W'($urandom_range(21'h7F));
            1: cp = DATA_W'($urandom_range(21'hD7FF, 21'h80));
            2: cp = DATA_W'($urandom_range(21'hFFFF, 21'hE000));
            3, 4: cp = DATA_W'($urandom_range(CP_MAX, SUPP_BASE));
            default:
                case ($urandom_range(5))
                    0: cp = '0;
                    1: cp = 21'hD7FF;
                    2: cp = 21'hE000;
                    3: cp = 21'hFFFF;
                    4: cp = SUPP_BASE;
                    default: cp = CP_MAX;
                endcase
        endcase
        return cp;
    endfunction

    task automatic send_char_bytes(input logic [DATA_W-1:0] cp);
        logic [DATA_W-1:0] d;
        if (cp < SUPP_BASE)
            send_word(cp[15:0]);
        else
        begin
            d = cp - SUPP_BASE;
            send_word(LEAD_LO | {6'b0, d[19:10]});
            send_word(TRAIL_LO | {6'b0, d[9:0]});
        end
    endtask

    task automatic random_request();
        int unsigned pick;
        logic [DATA_W-1:0] bad_cp;
        pick = $urandom_range(99);
        if (pick < 35)
            send_char_bytes(pick_code_point());
        else if (pick < 43)
            send_word($urandom_range(1) ? WORD_BOM : WORD_BOM_SWAP);
        else if (pick < 63)
            send_item(KIND_ENCODE, pick_code_point());
        else if (pick < 70)
        begin
            if ($urandom_range(1))
                bad_cp = DATA_W'($urandom_range(21'hDFFF, 21'hD800));
            else
                bad_cp = DATA_W'($urandom_range(21'h1FFFFF, CP_MAX + 1));
            send_item(KIND_ENCODE, bad_cp);
        end
        else if (pick < 78)
            send_item(KIND_DECODE, DATA_W'($urandom));
        else if (pick < 84)
            send_word(TRAIL_LO | 16'($urandom_range(10'h3FF)));
        else if (pick < 89)
        begin
            // lead followed by a word that is usually not a trail
            send_word(LEAD_LO | 16'($urandom_range(10'h3FF)));
            send_word(16'($urandom));
        end
        else if (pick < 97)
            send_item(KIND_END, DATA_W'($urandom));
        else
            send_item(KIND_NOP, DATA_W'($urandom));
    endtask

    task automatic directed_part();
        write_reg(REG_START_BIG_ENDIAN, 1'b1);
        write_reg(REG_START_BOM_FLAG, 1'b1);
        send_item(KIND_ENCODE, 21'h41);      // mark goes out first
        send_item(KIND_ENCODE, CP_MAX);
        send_item(KIND_ENCODE, 21'hD800);
        send_item(KIND_ENCODE, 21'h1FFFFF);
        send_pair(8'hDB, 8'hFF);             // highest surrogate pair
        send_pair(8'hDF, 8'hFF);
        send_pair(8'hDC, 8'h00);             // lone trail
        send_pair(8'hD8, 8'h00);             // lead then plain word
        send_pair(8'h00, 8'h41);
        send_pair(8'hFF, 8'hFE);             // swapped mark flips to little endian
        send_pair(8'h41, 8'h00);
        send_item(KIND_DECODE, 21'h1FFF12);  // only the low byte counts
        send_item(KIND_END, '0);
        send_item(KIND_END, 21'h1FFFFF);
        send_pair(8'h00, 8'hD8);             // lead left open at end
        send_item(KIND_END, '0);
        send_item(KIND_NOP, 21'h1FFFFF);
        drain();
        write_reg(REG_START_BOM_FLAG, 1'b1);
        send_item(KIND_ENCODE, 21'hDFFF);    // mark bytes then invalid character
        drain();
    endtask

    initial
    begin
        int unsigned idle_tab[4];
        int unsigned stall_tab[4];
        bit be_tab[4];
        bit bom_tab[4];
        int unsigned start_count;
        rst_n = 1'b0;
        sb = new();
        idle_tab = '{0, 84, 0, 15};
        stall_tab = '{0, 0, 84, 15};
        be_tab = '{0, 1, 0, 1};
        bom_tab = '{0, 0, 1, 1};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            write_reg(REG_START_BIG_ENDIAN, be_tab[p]);
            write_reg(REG_START_BOM_FLAG, bom_tab[p]);
            start_count = requests_sent;
            while (requests_sent - start_count < RANDOM_PER_PHASE)
                random_request();
            drain();
        end
        recv_stall_pct = 0;
        $display("sent %0d requests, checked %0d results, %0d register writes",
                 requests_sent, results_seen, reg_writes);
        $display("directed edge cases then four handshake pressure phases");
        if (mismatch_count == 0)
            $display("utf16_byte_stream_codec_top verification clean");
        else
            $display("utf16_byte_stream_codec_top verification failed");
        $finish;
    end

endmodule
`default_nettype wire
